FILE: hdl/fkm_pkg.sv
// ----------------------------------------------------------------------------
// fkm_pkg - shared types and constants of the keyword matcher
// Keyword storage sizes, register map, byte codes and the classified-beat type.
// ----------------------------------------------------------------------------
package fkm_pkg;

	localparam int KW_BYTES    = 32;               // longest keyword
	localparam int CHAR_REGS   = 4;                // 64-bit keyword registers
	localparam int LEN_W       = 6;
	localparam int ADDR_W      = 6;
	localparam int DATA_W      = 64;
	localparam int REG_IDX_W   = 3;
	localparam int POS_W       = $clog2(KW_BYTES);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	// register indexes (byte address = 8 * index)
	localparam logic [REG_IDX_W-1:0] REG_CHARS_0 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CHARS_1 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CHARS_2 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CHARS_3 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LENGTH  = 3'd4;

	localparam logic [LEN_W-1:0] LEN_RESET = 6'd1;
	localparam logic [LEN_W-1:0] LEN_MAX   = 6'(KW_BYTES);

	// byte codes
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_ESC     = 8'h1B;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_BRACKET = 8'h5B;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_BIT   = 8'h20;

	typedef logic [KW_BYTES-1:0][7:0]      kw_t;
	typedef logic [CHAR_REGS-1:0][DATA_W-1:0] chars_t;

	// one classified byte handed from the front to the back
	typedef struct packed {
		logic [7:0] ch;         // folded (or raw trail) byte
		logic       use_byte;   // byte takes part in matching
		logic       may_start;  // byte may begin a match
		logic       clear;      // new text: clear match state first
	} item_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} qstat_t;

	typedef struct packed {
		logic found;
		logic match_here;
	} result_t;

endpackage

FILE: hdl/filler_skipping_keyword_matcher.sv
// Throughput: one text byte per cycle, sustained while neither the queue nor the result buffer is full.
// Result path: an accepted byte is written to the queue, then the matcher update writes its
//   result to the result buffer that feeds the result ports; a stall on either side holds it.
// Up to four classified beats and two results wait inside, so push and pop stall apart.
// Reset (arst_n low, asynchronous): queues empty, match state clear, keyword all zero,
//   pattern_length 1. No clearing pass; the block takes bytes right after reset.
// ----------------------------------------------------------------------------
// filler_skipping_keyword_matcher - case-folding keyword search over a byte stream
// Skips spaces, newlines and escape sequences, tracks Big5 pairs, Shift-And match.
// ----------------------------------------------------------------------------
module filler_skipping_keyword_matcher import fkm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// text side
	input  logic              push,
	output logic              full,
	input  logic [7:0]        text_byte,
	input  logic              text_start,
	// result side
	output logic              empty,
	input  logic              pop,
	output logic              found,
	output logic              match_here
);

	// ------------------------------------------------------------------
	// Configuration registers: four keyword words and the length.
	// Registers sit at 8-byte strides; the low address bits are ignored.
	// ------------------------------------------------------------------
	chars_t             chars_q;
	logic [LEN_W-1:0]   len_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic               cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q <= '0;
			len_q   <= LEN_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_CHARS_0: chars_q[0] <= pwdata;
				REG_CHARS_1: chars_q[1] <= pwdata;
				REG_CHARS_2: chars_q[2] <= pwdata;
				REG_CHARS_3: chars_q[3] <= pwdata;
				REG_LENGTH:  len_q      <= pwdata[LEN_W-1:0];
				default: ;  // unmapped: drop the write
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CHARS_0: prdata = chars_q[0];
			REG_CHARS_1: prdata = chars_q[1];
			REG_CHARS_2: prdata = chars_q[2];
			REG_CHARS_3: prdata = chars_q[3];
			REG_LENGTH:  prdata = DATA_W'(len_q);
			default:     prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Front: classify every accepted beat and write it to the queue.
	// ------------------------------------------------------------------
	item_t  front_item, head_item;
	qstat_t mid_stat;
	logic   in_accept, head_take;

	assign full      = mid_stat.full;
	assign in_accept = push & ~mid_stat.full;

	fkm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_accept),
		.text_byte  (text_byte),
		.text_start (text_start),
		.item       (front_item)
	);

	fkm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_accept),
		.wr_item (front_item),
		.rd_en   (head_take),
		.rd_item (head_item),
		.stat    (mid_stat)
	);

	// ------------------------------------------------------------------
	// Back: Shift-And update on the queue head, results into a two-entry
	// buffer that the result side pops.
	// ------------------------------------------------------------------
	fkm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head_item),
		.head_valid     (~mid_stat.empty),
		.head_take      (head_take),
		.kw             (kw_t'(chars_q)),
		.pattern_length (len_q),
		.found          (found),
		.match_here     (match_here),
		.empty          (empty),
		.pop            (pop)
	);

`ifndef SYNTHESIS
	// a completed match always carries the sticky found flag
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (!match_here || found))
		else $error("match_here without found");

	// queue occupancy never exceeds its depth
	assert property (@(posedge clk) disable iff (!arst_n)
		mid_stat.count <= QCNT_W'(QUEUE_DEPTH))
		else $error("beat queue overflow");

	// an accepted beat that is not drained the same cycle grows the queue
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && !head_take) |=> mid_stat.count == $past(mid_stat.count) + 1'b1)
		else $error("beat queue lost a write");

	// the matcher never takes from an empty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		head_take |-> !mid_stat.empty)
		else $error("matcher read an empty queue");
`endif

endmodule

FILE: hdl/fkm_front.sv
// ----------------------------------------------------------------------------
// fkm_front - byte classifier
// Tracks escape sequences and Big5 lead bytes, folds case, tags each beat.
// ----------------------------------------------------------------------------
module fkm_front import fkm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] text_byte,
	input  logic       text_start,
	output item_t      item
);

	logic in_escape_q, lead_seen_q;
	logic esc_cur, lead_cur, esc_nxt, lead_nxt;
	logic is_body;

	always_comb begin
		esc_cur  = in_escape_q & ~text_start;
		lead_cur = lead_seen_q & ~text_start;
		esc_nxt  = esc_cur;
		lead_nxt = lead_cur;
		is_body  = (text_byte >= CH_ZERO && text_byte <= CH_NINE) ||
		           text_byte == CH_SEMI || text_byte == CH_BRACKET;
		item.ch        = text_byte;
		item.use_byte  = 1'b0;
		item.may_start = 1'b0;
		item.clear     = text_start;
		priority if (esc_cur) begin
			esc_nxt = is_body;
		end else if (lead_cur) begin
			// trail byte: compare raw, extend only
			lead_nxt      = 1'b0;
			item.use_byte = 1'b1;
		end else if (text_byte == CH_SPACE || text_byte == CH_NEWLINE) begin
			// filler: drop
		end else if (text_byte == CH_ESC) begin
			esc_nxt = 1'b1;
		end else begin
			lead_nxt = text_byte[7];
			if (text_byte >= CH_UPPER_A && text_byte <= CH_UPPER_Z) begin
				item.ch = text_byte | CASE_BIT;
			end
			item.use_byte  = 1'b1;
			item.may_start = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_escape_q <= 1'b0;
			lead_seen_q <= 1'b0;
		end else if (accept) begin
			in_escape_q <= esc_nxt;
			lead_seen_q <= lead_nxt;
		end
	end

endmodule

FILE: hdl/fkm_queue.sv
// ----------------------------------------------------------------------------
// fkm_queue - classified-beat queue
// Short FIFO between classifier and matcher so each side stalls on its own.
// ----------------------------------------------------------------------------
module fkm_queue import fkm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  item_t  wr_item,
	input  logic   rd_en,
	output item_t  rd_item,
	output qstat_t stat
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr, do_rd;

	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;
	assign do_wr      = wr_en & ~stat.full;
	assign do_rd      = rd_en & ~stat.empty;
	assign rd_item    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hdl/fkm_back.sv
// ----------------------------------------------------------------------------
// fkm_back - Shift-And matcher and result buffer
// Updates the match vector and sticky found flag, queues results for pop.
// ----------------------------------------------------------------------------
module fkm_back import fkm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  item_t            head,
	input  logic             head_valid,
	output logic             head_take,
	input  kw_t              kw,
	input  logic [LEN_W-1:0] pattern_length,
	output logic             found,
	output logic             match_here,
	output logic             empty,
	input  logic             pop
);

	logic [KW_BYTES-1:0] pm_q, pm_base, vec, char_mask, len_mask;
	logic                found_q, found_base, hit;
	logic [LEN_W-1:0]    n_act;
	logic [POS_W-1:0]    top_pos;
	logic                active;

	result_t             obuf_q [2];
	logic                owr_q, ord_q;
	logic [1:0]          ocnt_q;
	logic                do_pop;

	assign n_act   = (pattern_length > LEN_MAX) ? LEN_MAX : pattern_length;
	assign top_pos = POS_W'(n_act - 1'b1);
	assign active  = head.use_byte && (n_act != '0);

	always_comb begin
		for (int i = 0; i < KW_BYTES; i++) begin
			char_mask[i] = (kw[i] == head.ch);
			len_mask[i]  = (LEN_W'(i) < n_act);
		end
	end

	assign pm_base    = head.clear ? '0 : pm_q;
	assign found_base = head.clear ? 1'b0 : found_q;
	assign vec = {pm_base[KW_BYTES-2:0], head.may_start} & char_mask & len_mask;
	assign hit = active & vec[top_pos];

	// take a beat whenever the result buffer has a free slot
	assign head_take = head_valid && (ocnt_q != 2'd2);
	assign do_pop    = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_q    <= '0;
			found_q <= 1'b0;
		end else if (head_take) begin
			pm_q    <= active ? vec : pm_base;
			found_q <= found_base | hit;
		end
	end

	always_ff @(posedge clk) begin
		if (head_take) begin
			obuf_q[owr_q] <= '{found: found_base | hit, match_here: hit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (head_take) owr_q <= ~owr_q;
			if (do_pop)    ord_q <= ~ord_q;
			unique case ({head_take, do_pop})
				2'b10:   ocnt_q <= ocnt_q + 1'b1;
				2'b01:   ocnt_q <= ocnt_q - 1'b1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	assign empty      = (ocnt_q == '0);
	assign found      = obuf_q[ord_q].found;
	assign match_here = obuf_q[ord_q].match_here;

endmodule
